>>> src/cdq_pkg.sv
// cdq_pkg: request codes and cell commands for the circular deque.
// Used by the cell chain and the top level; no dependencies.

package cdq_pkg;

   // Request codes carried in the operation field (code 7 is unused)
   typedef enum logic [2:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5,
      OP_REVERSE    = 3'd6
   } op_type;

   // Command broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CELL_HOLD   = 3'd0,   // keep contents
      CELL_SHR    = 3'd1,   // take left neighbour (insert at physical front)
      CELL_SHL    = 3'd2,   // take right neighbour (remove physical front)
      CELL_APPEND = 3'd3,   // first free cell takes the pushed word
      CELL_TRIM   = 3'd4    // last held cell drops its word
   } cell_cmd_type;

endpackage

>>> src/cdq_if.sv
// cdq_if: valid/ready channel interfaces for request and response words.
// Depends on cdq_pkg.

interface cdq_req_if import cdq_pkg::*; #(
   parameter int DATA_WIDTH = 32
) ();
   logic                  valid;
   logic                  ready;
   logic [2:0]            operation;
   logic [DATA_WIDTH-1:0] push_value;

   modport source (output valid, output operation, output push_value, input ready);
   modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface cdq_rsp_if import cdq_pkg::*; #(
   parameter int DATA_WIDTH  = 32,
   parameter int COUNT_WIDTH = 8
) ();
   logic                   valid;
   logic                   ready;
   logic [DATA_WIDTH-1:0]  read_value;
   logic                   success;
   logic [COUNT_WIDTH-1:0] entry_count;
   logic                   is_empty;
   logic                   is_full;

   modport source (output valid, output read_value, output success, output entry_count,
                   output is_empty, output is_full, input ready);
   modport sink   (input valid, input read_value, input success, input entry_count,
                   input is_empty, input is_full, output ready);
endinterface

>>> src/cdq_cell.sv
// cdq_cell: one slot of the deque chain, holding a word and an occupied flag.
// Depends on cdq_pkg for the cell command type.

module cdq_cell import cdq_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_cmd_type          cmd,
   input  logic [DATA_WIDTH-1:0] push_value,
   input  logic [DATA_WIDTH-1:0] left_data,
   input  logic                  left_occ,
   input  logic [DATA_WIDTH-1:0] right_data,
   input  logic                  right_occ,
   output logic [DATA_WIDTH-1:0] data_out,
   output logic                  occ_out,
   output logic [DATA_WIDTH-1:0] last_word
);

   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic                  occ_ff, occ_in;

   // Next contents from the broadcast command and both neighbours
   always_comb begin
      data_in = data_ff;
      occ_in  = occ_ff;
      case (cmd)
         CELL_SHR: begin
            data_in = left_data;
            occ_in  = left_occ;
         end
         CELL_SHL: begin
            data_in = right_data;
            occ_in  = right_occ;
         end
         CELL_APPEND: begin
            // only the first free cell sits next to a held one
            if (!occ_ff && left_occ) begin
               data_in = push_value;
            end
            occ_in = occ_ff | left_occ;
         end
         CELL_TRIM: begin
            occ_in = occ_ff & right_occ;
         end
         default: begin
         end
      endcase
   end

   // Occupied flag is control state; the word needs no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out  = data_ff;
   assign occ_out   = occ_ff;
   // word offered for the back read, zero unless this is the last held cell
   assign last_word = (occ_ff && !right_occ) ? data_ff : '0;

endmodule

>>> src/circular_deque.sv
// circular_deque: bounded double-ended queue built as a chain of cdq_cell slots.
// Depends on cdq_pkg, cdq_if (cdq_req_if, cdq_rsp_if) and cdq_cell.
//
//   channel   dir   handshake        payload
//   req_chan  in    valid / ready    operation, push_value
//   rsp_chan  out   valid / ready    read_value, success, entry_count, is_empty, is_full
//
// One word per cycle while the response side is not stalled: a request is applied to the whole cell chain in the cycle
// it is accepted and its response is registered at that same edge.
// The physical front is cell 0 and the held words are packed from there; the
// back word is the single last held cell, gathered by an OR over the chain.
// Reset empties the chain and clears the reverse flag.
// A stalled response holds the request side only while it is still unread.

module circular_deque import cdq_pkg::*; #(
   parameter int DEPTH      = 128,
   parameter int DATA_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   cdq_req_if.sink   req_chan,
   cdq_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic                  accept;
   logic                  empty, full;
   cell_cmd_type          cell_cmd;

   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rev_ff, rev_in;
   logic [DATA_WIDTH-1:0] rd_value;
   logic                  ok;

   logic                  rsp_valid_ff;
   logic [DATA_WIDTH-1:0] rsp_value_ff;
   logic                  rsp_ok_ff;
   logic [CNT_W-1:0]      rsp_count_ff;
   logic                  rsp_empty_ff, rsp_full_ff;

   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic [DATA_WIDTH-1:0] cell_last [DEPTH];
   logic [DEPTH-1:0]      cell_occ;
   logic [DATA_WIDTH-1:0] back_word;

   assign accept = req_chan.valid && req_chan.ready;
   assign empty  = (count_ff == '0);
   assign full   = (count_ff == CNT_W'(DEPTH));

   // Cell chain, neighbours wired in a row; cell 0 sees the pushed word on its left, the last cell an empty right
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data, right_data;
      logic                  left_occ, right_occ;

      if (i == 0) begin : g_first
         assign left_data = req_chan.push_value;
         assign left_occ  = 1'b1;
      end else begin : g_left
         assign left_data = cell_data[i-1];
         assign left_occ  = cell_occ[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data = '0;
         assign right_occ  = 1'b0;
      end else begin : g_right
         assign right_data = cell_data[i+1];
         assign right_occ  = cell_occ[i+1];
      end

      cdq_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cell_cmd),
         .push_value (req_chan.push_value),
         .left_data  (left_data),
         .left_occ   (left_occ),
         .right_data (right_data),
         .right_occ  (right_occ),
         .data_out   (cell_data[i]),
         .occ_out    (cell_occ[i]),
         .last_word  (cell_last[i])
      );
   end

   // Back word: at most one cell offers a non-zero word
   always_comb begin
      back_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_word = back_word | cell_last[i];
      end
   end

   // Request decode: chain command, next count and flag, response word
   always_comb begin
      cell_cmd = CELL_HOLD;
      count_in = count_ff;
      rev_in   = rev_ff;
      rd_value = '0;
      ok       = 1'b0;
      if (accept) begin
         case (req_chan.operation)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
               if (!full) begin
                  cell_cmd = ((req_chan.operation == OP_PUSH_FRONT) != rev_ff) ?
                             CELL_SHR : CELL_APPEND;
                  count_in = count_ff + CNT_W'(1);
                  ok       = 1'b1;
               end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
               if (!empty) begin
                  if ((req_chan.operation == OP_POP_FRONT) != rev_ff) begin
                     cell_cmd = CELL_SHL;
                     rd_value = cell_data[0];
                  end else begin
                     cell_cmd = CELL_TRIM;
                     rd_value = back_word;
                  end
                  count_in = count_ff - CNT_W'(1);
                  ok       = 1'b1;
               end
            end
            OP_PEEK_FRONT, OP_PEEK_BACK: begin
               if (!empty) begin
                  rd_value = ((req_chan.operation == OP_PEEK_FRONT) != rev_ff) ?
                             cell_data[0] : back_word;
                  ok       = 1'b1;
               end
            end
            OP_REVERSE: begin
               rev_in = !rev_ff;
               ok     = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Count and direction flag
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rev_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         rev_ff   <= rev_in;
      end
   end

   // Response word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_value_ff <= rd_value;
         rsp_ok_ff    <= ok;
         rsp_count_ff <= count_in;
         rsp_empty_ff <= (count_in == '0);
         rsp_full_ff  <= (count_in == CNT_W'(DEPTH));
      end
   end

   assign req_chan.ready       = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.read_value  = rsp_value_ff;
   assign rsp_chan.success     = rsp_ok_ff;
   assign rsp_chan.entry_count = rsp_count_ff;
   assign rsp_chan.is_empty    = rsp_empty_ff;
   assign rsp_chan.is_full     = rsp_full_ff;

endmodule

>>> dv/cdq_response_checker.sv
// cdq_response_checker: watches the request and response channels of the
// circular deque, predicts every response word and compares it on arrival.
// Depends on cdq_pkg and the channel interfaces in cdq_if.
`timescale 1ns / 1ps

module cdq_response_checker import cdq_pkg::*; #(
   parameter int DEPTH       = 128,
   parameter int DATA_WIDTH  = 32,
   parameter int COUNT_WIDTH = 8
) (
   input  logic clock,
   input  logic reset,
   cdq_req_if   req_mon,
   cdq_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   answers_outstanding
);

   localparam int IDX_W = $clog2(DEPTH);

   typedef struct packed {
      logic [DATA_WIDTH-1:0]  read_value;
      logic                   success;
      logic [COUNT_WIDTH-1:0] entry_count;
      logic                   is_empty;
      logic                   is_full;
   } deque_answer_type;

   // Shadow of the deque: circular store, end pointers, fill level, direction
   logic [DATA_WIDTH-1:0]  slot_word [DEPTH];
   logic [IDX_W-1:0]       head_slot;
   logic [IDX_W-1:0]       tail_slot;
   logic [COUNT_WIDTH-1:0] held;
   logic                   mirrored;

   deque_answer_type awaited_answers [$];
   int               mismatches = 0;

   function automatic logic [IDX_W-1:0] slot_after(logic [IDX_W-1:0] s);
      return (s == IDX_W'(DEPTH - 1)) ? '0 : s + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] slot_before(logic [IDX_W-1:0] s);
      return (s == '0) ? IDX_W'(DEPTH - 1) : s - 1'b1;
   endfunction

   // Apply one request to the shadow deque and return the response it should give
   function automatic deque_answer_type next_deque_answer(logic [2:0] code,
                                                          logic [DATA_WIDTH-1:0] word);
      deque_answer_type ans;
      logic             at_front;
      ans = '0;
      case (code)
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (held != DEPTH) begin
               // logical front is the physical front unless mirrored
               at_front = (code == OP_PUSH_FRONT) ^ mirrored;
               if (at_front) begin
                  head_slot = slot_before(head_slot);
                  slot_word[head_slot] = word;
               end else begin
                  slot_word[tail_slot] = word;
                  tail_slot = slot_after(tail_slot);
               end
               held = held + 1'b1;
               ans.success = 1'b1;
            end
         end
         OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
            if (held != 0) begin
               at_front = ((code == OP_POP_FRONT) || (code == OP_PEEK_FRONT)) ^ mirrored;
               ans.read_value = at_front ? slot_word[head_slot]
                                         : slot_word[slot_before(tail_slot)];
               if ((code == OP_POP_FRONT) || (code == OP_POP_BACK)) begin
                  if (at_front) head_slot = slot_after(head_slot);
                  else          tail_slot = slot_before(tail_slot);
                  held = held - 1'b1;
               end
               ans.success = 1'b1;
            end
         end
         OP_REVERSE: begin
            mirrored = ~mirrored;
            ans.success = 1'b1;
         end
         default: ;   // unused code: no effect
      endcase
      ans.entry_count = held;
      ans.is_empty    = (held == 0);
      ans.is_full     = (held == DEPTH);
      return ans;
   endfunction

   // Responses are matched before the request of the same edge is predicted
   always @(posedge clock) begin : watch
      deque_answer_type seen;
      deque_answer_type want;
      if (reset) begin
         head_slot = '0;
         tail_slot = '0;
         held      = '0;
         mirrored  = 1'b0;
         awaited_answers.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = '{read_value: rsp_mon.read_value, success: rsp_mon.success,
                     entry_count: rsp_mon.entry_count, is_empty: rsp_mon.is_empty,
                     is_full: rsp_mon.is_full};
            if (awaited_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response word with none outstanding: read %h ok %0d",
                           $time, seen.read_value, seen.success);
            end else begin
               want = awaited_answers.pop_front();
               if (seen !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: expected read %h ok %0d count %0d empty %0d full %0d",
                              $time, want.read_value, want.success, want.entry_count,
                              want.is_empty, want.is_full);
                     $display("%0t:      got read %h ok %0d count %0d empty %0d full %0d",
                              $time, seen.read_value, seen.success, seen.entry_count,
                              seen.is_empty, seen.is_full);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            awaited_answers.push_back(next_deque_answer(req_mon.operation,
                                                        req_mon.push_value));
      end
      mismatch_count      <= mismatches;
      answers_outstanding <= awaited_answers.size();
   end

endmodule

>>> dv/tb_circular_deque.sv
// tb_circular_deque: drives request words into the circular deque with random
// idling and receiver stalls; cdq_response_checker predicts and compares.
// Depends on cdq_pkg, cdq_if, circular_deque and cdq_response_checker.
`timescale 1ns / 1ps

module tb_circular_deque import cdq_pkg::*; ();

   localparam int DEPTH       = 128;
   localparam int DATA_WIDTH  = 32;
   localparam int COUNT_WIDTH = 8;

   localparam logic [2:0] OP_UNUSED = 3'd7;

   localparam int ITEM_TARGET      = 1750;
   localparam int CALM_FROM        = 1500;
   localparam int LONG_HOLD_AT     = 700;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT      = 400000;

   typedef enum int {FILL_UP, DRAIN_DOWN, CHURN} phase_kind_type;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   answers_outstanding;
   int   cycle_count;
   bit   calm;
   bit   long_hold_due;

   cdq_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_bus ();
   cdq_rsp_if #(.DATA_WIDTH(DATA_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) rsp_bus ();

   circular_deque #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   cdq_response_checker #(
      .DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)
   ) answer_check (
      .clock               (clock),
      .reset               (reset),
      .req_mon             (req_bus),
      .rsp_mon             (rsp_bus),
      .mismatch_count      (mismatch_count),
      .answers_outstanding (answers_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // Receiver: mostly ready, random stall bursts, one long hold-off mid-run
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 15) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Offer one request word and hold it until taken, then maybe idle a while
   task automatic send_word(input logic [2:0] code, input logic [DATA_WIDTH-1:0] word);
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= code;
      req_bus.push_value <= word;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   function automatic logic [2:0] pick_operation(phase_kind_type kind);
      int roll;
      int push_pct;
      int pop_pct;
      case (kind)
         FILL_UP:    begin push_pct = 80; pop_pct = 8;  end
         DRAIN_DOWN: begin push_pct = 8;  pop_pct = 80; end
         default:    begin push_pct = 40; pop_pct = 35; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < push_pct)
         return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      roll -= push_pct;
      if (roll < pop_pct)
         return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
      roll -= pop_pct;
      if (roll < 2)
         return OP_UNUSED;
      if (roll < 5)
         return OP_REVERSE;
      return $urandom_range(0, 1) ? OP_PEEK_FRONT : OP_PEEK_BACK;
   endfunction

   function automatic logic [DATA_WIDTH-1:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return DATA_WIDTH'($urandom);
      endcase
   endfunction

   // Stimulus and verdict
   initial begin
      phase_kind_type kind;
      int             sent;
      int             run_len;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.operation  <= OP_PUSH_BACK;
      req_bus.push_value <= '0;
      calm          = 1'b0;
      long_hold_due = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: every request but push front on an empty deque, then both ends with edge words
      send_word(OP_PEEK_FRONT, '0);
      send_word(OP_PEEK_BACK,  '0);
      send_word(OP_POP_FRONT,  '0);
      send_word(OP_POP_BACK,   '0);
      send_word(OP_UNUSED,     '1);
      send_word(OP_REVERSE,    '0);
      send_word(OP_REVERSE,    '0);
      send_word(OP_PUSH_BACK,  '0);
      send_word(OP_PUSH_BACK,  '1);
      send_word(OP_PUSH_FRONT, 32'hA5A5_A5A5);
      send_word(OP_PUSH_FRONT, 32'h5A5A_5A5A);
      send_word(OP_PEEK_FRONT, '0);
      send_word(OP_PEEK_BACK,  '0);
      send_word(OP_REVERSE,    '0);
      send_word(OP_PEEK_FRONT, '0);
      send_word(OP_PEEK_BACK,  '0);
      send_word(OP_PUSH_FRONT, 32'h8000_0001);   // lands at the physical back
      send_word(OP_POP_BACK,   '0);
      send_word(OP_POP_FRONT,  '0);
      send_word(OP_UNUSED,     32'h1234_5678);
      send_word(OP_REVERSE,    '0);
      send_word(OP_POP_FRONT,  '0);
      send_word(OP_POP_BACK,   '0);
      send_word(OP_POP_BACK,   '0);
      send_word(OP_POP_FRONT,  '0);              // empty again

      // Random: fill, drain and churn runs so the deque swings between empty and full
      sent = 0;
      while (sent < ITEM_TARGET) begin
         kind    = phase_kind_type'($urandom_range(0, 2));
         run_len = (kind == CHURN) ? $urandom_range(60, 200) : $urandom_range(200, 260);
         repeat (run_len) begin
            if (sent >= ITEM_TARGET) break;
            if (sent == LONG_HOLD_AT) long_hold_due = 1'b1;
            if (sent >= CALM_FROM)    calm = 1'b1;
            send_word(pick_operation(kind), pick_word());
            sent++;
         end
      end
      req_bus.valid <= 1'b0;

      // Drain the responses still owed, then allow for the response register
      @(posedge clock);
      while (answers_outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && answers_outstanding == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
